// File: hdl/max_3x3_window_sum_assert.svh
// Assertion macros for the 3x3 window sum block.
`ifndef MAX_3X3_WINDOW_SUM_ASSERT_SVH
`define MAX_3X3_WINDOW_SUM_ASSERT_SVH

// expr holds at every edge out of reset
`define MXS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// cons holds in the same cycle as ante
`define MXS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// cons holds in the cycle after ante
`define MXS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: hdl/mxs_pkg.sv
`default_nettype none

package mxs_pkg;

    localparam int MAX_COLUMNS  = 1024;
    localparam int DATA_BITS    = 16;
    localparam int SUM_BITS     = DATA_BITS + 4;
    localparam int ROW_SUM_BITS = DATA_BITS + 2;
    localparam int ROW_LIMIT    = 1024;
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int COL_BITS     = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS     = $clog2(ROW_LIMIT);
    localparam int CMP_BITS     = (COL_BITS + 1 > CFG_BITS) ? COL_BITS + 1 : CFG_BITS;
    localparam int RES_DEPTH    = 5;
    localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
    localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_COUNT = CFG_IDX_BITS'(1);
    localparam logic [CFG_BITS-1:0]     CFG_COUNT_RESET  = CFG_BITS'(3);

    typedef logic signed [DATA_BITS-1:0]    t_data;
    typedef t_data [2:0]                    t_row;
    typedef t_row [2:0]                     t_win;
    typedef logic signed [ROW_SUM_BITS-1:0] t_row_sum;
    typedef logic signed [SUM_BITS-1:0]     t_sum;

    typedef struct packed {
        logic shift;
        logic snap;
    } t_cell_ctl;

    typedef struct packed {
        logic found;
        t_sum best_sum;
        t_win win;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/mxs_elem_if.sv
`default_nettype none

interface mxs_elem_if import mxs_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

`default_nettype wire

// File: hdl/mxs_res_if.sv
`default_nettype none

interface mxs_res_if import mxs_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  found;
    t_sum  best_sum;
    t_data top_left;
    t_data top_mid;
    t_data top_right;
    t_data mid_left;
    t_data center;
    t_data mid_right;
    t_data bottom_left;
    t_data bottom_mid;
    t_data bottom_right;

    modport source (
        output valid, output found, output best_sum,
        output top_left, output top_mid, output top_right,
        output mid_left, output center, output mid_right,
        output bottom_left, output bottom_mid, output bottom_right,
        input ready
    );
    modport sink (
        input valid, input found, input best_sum,
        input top_left, input top_mid, input top_right,
        input mid_left, input center, input mid_right,
        input bottom_left, input bottom_mid, input bottom_right,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/max_3x3_window_sum.sv
// Streams a signed matrix in raster order, one element per word, and returns one word
// per frame after the last element: a found flag, the largest 3x3 window sum and the
// nine values of that window (ties keep the earliest window). The block takes one
// element every cycle while fewer than five results are pending; a word passes the
// line-store read, the window shift, the row sums and the best-window compare before
// a frame's result enters the output queue. Each of the two line stores is a single-port-write,
// single-port-read RAM written once per element. The output queue holds five results;
// input stalls only while five results are pending. Program row_count and column_count
// between frames.
`default_nettype none

`include "max_3x3_window_sum_assert.svh"

module max_3x3_window_sum import mxs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    mxs_elem_if.sink                i_elem,
    mxs_res_if.source               o_res
);

    logic [CFG_BITS-1:0]     r_cfg_rows;
    logic [CFG_BITS-1:0]     r_cfg_cols;
    logic [ROW_BITS-1:0]     r_row_pos;
    logic [COL_BITS-1:0]     r_col_pos;
    logic [RES_CNT_BITS-1:0] r_pend;

    logic                r_s1_vld;
    logic                r_s1_win;
    logic                r_s1_last;
    logic [COL_BITS-1:0] r_s1_addr;
    t_data               r_s1_x;
    logic                r_s2_vld;
    logic                r_s2_win;
    logic                r_s2_last;
    logic                r_s3_vld;
    logic                r_s3_win;
    logic                r_s3_last;

    logic                r_fwd_vld;
    logic [COL_BITS-1:0] r_fwd_addr;
    t_data               r_fwd_a;
    t_data               r_fwd_b;

    logic r_have;
    t_sum r_best_total;
    t_win r_best;

    logic [CMP_BITS-1:0]  cols_eff;
    logic [CMP_BITS-1:0]  cols_cfg;
    logic [CFG_BITS-1:0]  rows_eff;
    logic [COL_BITS-1:0]  col_inc;
    logic                 col_last;
    logic                 row_last;
    logic                 win_full;
    logic                 in_acc;
    logic                 out_acc;
    logic                 frame_last;
    logic [DATA_BITS-1:0] ram_a_rdata;
    logic [DATA_BITS-1:0] ram_b_rdata;
    t_data                up1;
    t_data                up2;
    t_cell_ctl            cell_ctl;
    t_row                 snap_top;
    t_row                 snap_mid;
    t_row                 snap_bot;
    t_row_sum             sum_top;
    t_row_sum             sum_mid;
    t_row_sum             sum_bot;
    t_win                 snap_win;
    t_sum                 total;
    logic                 take;
    logic                 have_nx;
    t_sum                 sum_nx;
    t_win                 win_nx;
    logic                 push;
    t_result              push_data;
    t_result              head;
    logic                 head_vld;
    logic [RES_CNT_BITS-1:0] n_pend;

    always_comb begin
        cols_cfg = CMP_BITS'(r_cfg_cols);
        if (r_cfg_cols == '0) begin
            cols_eff = CMP_BITS'(1);
        end else if (cols_cfg > CMP_BITS'(MAX_COLUMNS)) begin
            cols_eff = CMP_BITS'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_cfg;
        end
        if (r_cfg_rows == '0) begin
            rows_eff = CFG_BITS'(1);
        end else if (r_cfg_rows > CFG_BITS'(ROW_LIMIT)) begin
            rows_eff = CFG_BITS'(ROW_LIMIT);
        end else begin
            rows_eff = r_cfg_rows;
        end
    end

    assign col_inc    = r_col_pos + COL_BITS'(1);
    assign col_last   = (CMP_BITS'(r_col_pos) + CMP_BITS'(1)) >= cols_eff;
    assign row_last   = (CFG_BITS'(r_row_pos) + CFG_BITS'(1)) >= rows_eff;
    assign win_full   = (r_row_pos >= ROW_BITS'(2)) && (r_col_pos >= COL_BITS'(2));
    assign frame_last = col_last && row_last;
    assign in_acc     = i_elem.valid && i_elem.ready;
    assign out_acc    = o_res.valid && o_res.ready;

    assign i_elem.ready = (r_pend < RES_CNT_BITS'(RES_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= CFG_COUNT_RESET;
            r_cfg_cols <= CFG_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_COUNT:    r_cfg_rows <= i_cfg_data;
                CFG_COLUMN_COUNT: r_cfg_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col_pos <= '0;
                r_row_pos <= row_last ? '0 : r_row_pos + ROW_BITS'(1);
            end else begin
                r_col_pos <= col_inc;
            end
        end
    end

    always_comb begin
        n_pend = r_pend;
        if ((in_acc && frame_last) && !out_acc) begin
            n_pend = r_pend + RES_CNT_BITS'(1);
        end else if (!(in_acc && frame_last) && out_acc) begin
            n_pend = r_pend - RES_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_have    <= 1'b0;
            r_pend    <= '0;
        end else begin
            r_s1_vld  <= in_acc;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_fwd_vld <= r_s1_vld;
            r_pend    <= n_pend;
            if (push) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_win   <= win_full;
        r_s1_last  <= frame_last;
        r_s1_addr  <= r_col_pos;
        r_s1_x     <= i_elem.element;
        r_s2_win   <= r_s1_win;
        r_s2_last  <= r_s1_last;
        r_s3_win   <= r_s2_win;
        r_s3_last  <= r_s2_last;
        r_fwd_addr <= r_s1_addr;
        r_fwd_a    <= r_s1_x;
        r_fwd_b    <= up1;
        if (take) begin
            r_best_total <= total;
            r_best       <= snap_win;
        end
    end

    // take the word written last cycle at the address read last cycle
    assign up1 = (r_fwd_vld && r_fwd_addr == r_s1_addr) ? r_fwd_a : t_data'(ram_a_rdata);
    assign up2 = (r_fwd_vld && r_fwd_addr == r_s1_addr) ? r_fwd_b : t_data'(ram_b_rdata);

    mxs_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_x),
        .i_raddr (r_col_pos),
        .o_rdata (ram_a_rdata)
    );

    mxs_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (up1),
        .i_raddr (r_col_pos),
        .o_rdata (ram_b_rdata)
    );

    assign cell_ctl.shift = r_s1_vld;
    assign cell_ctl.snap  = r_s2_vld;

    mxs_row_cell u_cell_top (
        .i_clk  (i_clk),
        .i_ctl  (cell_ctl),
        .i_data (up2),
        .o_snap (snap_top),
        .o_sum  (sum_top)
    );

    mxs_row_cell u_cell_mid (
        .i_clk  (i_clk),
        .i_ctl  (cell_ctl),
        .i_data (up1),
        .o_snap (snap_mid),
        .o_sum  (sum_mid)
    );

    mxs_row_cell u_cell_bot (
        .i_clk  (i_clk),
        .i_ctl  (cell_ctl),
        .i_data (r_s1_x),
        .o_snap (snap_bot),
        .o_sum  (sum_bot)
    );

    assign snap_win[0] = snap_top;
    assign snap_win[1] = snap_mid;
    assign snap_win[2] = snap_bot;

    assign total   = SUM_BITS'(sum_top) + SUM_BITS'(sum_mid) + SUM_BITS'(sum_bot);
    assign take    = r_s3_vld && r_s3_win && (!r_have || total > r_best_total);
    assign have_nx = r_have || take;
    assign sum_nx  = take ? total : r_best_total;
    assign win_nx  = take ? snap_win : r_best;
    assign push    = r_s3_vld && r_s3_last;

    always_comb begin
        push_data.found    = have_nx;
        push_data.best_sum = have_nx ? sum_nx : '0;
        push_data.win      = have_nx ? win_nx : '0;
    end

    mxs_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (out_acc),
        .o_valid (head_vld),
        .o_data  (head)
    );

    assign o_res.valid        = head_vld;
    assign o_res.found        = head.found;
    assign o_res.best_sum     = head.best_sum;
    assign o_res.top_left     = head.win[0][0];
    assign o_res.top_mid      = head.win[0][1];
    assign o_res.top_right    = head.win[0][2];
    assign o_res.mid_left     = head.win[1][0];
    assign o_res.center       = head.win[1][1];
    assign o_res.mid_right    = head.win[1][2];
    assign o_res.bottom_left  = head.win[2][0];
    assign o_res.bottom_mid   = head.win[2][1];
    assign o_res.bottom_right = head.win[2][2];

    `MXS_ASSERT_ALWAYS(a_pend_bound, i_clk, i_rst_n, r_pend <= RES_CNT_BITS'(RES_DEPTH))
    `MXS_ASSERT_IMPL(a_push_credit, i_clk, i_rst_n, push, r_pend != '0)
    `MXS_ASSERT_IMPL(a_out_credit, i_clk, i_rst_n, o_res.valid, r_pend != '0)
    `MXS_ASSERT_NEXT(a_col_step, i_clk, i_rst_n, in_acc && !col_last, r_col_pos == $past(col_inc))

endmodule

`default_nettype wire

// File: hdl/mxs_ram.sv
`default_nettype none

module mxs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/mxs_row_cell.sv
`default_nettype none

module mxs_row_cell import mxs_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_data     i_data,
    output t_row      o_snap,
    output t_row_sum  o_sum
);

    t_row     r_tap;
    t_row     r_snap;
    t_row_sum r_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_tap[0] <= r_tap[1];
            r_tap[1] <= r_tap[2];
            r_tap[2] <= i_data;
        end
        if (i_ctl.snap) begin
            r_snap <= r_tap;
            r_sum  <= ROW_SUM_BITS'(r_tap[0]) + ROW_SUM_BITS'(r_tap[1])
                    + ROW_SUM_BITS'(r_tap[2]);
        end
    end

    assign o_snap = r_snap;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

// File: hdl/mxs_res_fifo.sv
`default_nettype none

module mxs_res_fifo import mxs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result                 r_mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] r_wr_ptr;
    logic [RES_PTR_BITS-1:0] r_rd_ptr;
    logic [RES_CNT_BITS-1:0] r_count;
    logic [RES_PTR_BITS-1:0] n_wr_ptr;
    logic [RES_PTR_BITS-1:0] n_rd_ptr;
    logic [RES_CNT_BITS-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0
                     : r_wr_ptr + RES_PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0
                     : r_rd_ptr + RES_PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + RES_CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - RES_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire
